### design/scaw_pkg.sv
// Shared types and constants for the strided copy address walker.
// Holds configuration layout, register indexes, sequencer states and the
// request format of the shared arithmetic unit. Depends on nothing.
`default_nettype none

package scaw_pkg;

    localparam int MAX_RANK       = 4;
    localparam int AXIS_BITS      = 8;
    localparam int STRIDE_BITS    = 16;
    localparam int RANK_BITS      = 3;
    localparam int BASE_BITS      = 32;
    localparam int CSTRIDE_BITS   = 24;
    localparam int OFFSET_BITS    = 35;
    localparam int ESIZE_BITS     = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int SIZES_BITS     = MAX_RANK * AXIS_BITS;
    localparam int STRIDES_BITS   = MAX_RANK * STRIDE_BITS;
    localparam int CFG_DATA_BITS  = (SIZES_BITS > STRIDES_BITS) ? SIZES_BITS : STRIDES_BITS;
    localparam int IDX_BITS       = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANK           = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_SIZES     = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SOURCE_STRIDES = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_STRIDES   = CFG_INDEX_BITS'(3);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEST_CONTIG    = CFG_INDEX_BITS'(4);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ESIZE_LOG2     = CFG_INDEX_BITS'(5);

    typedef struct packed {
        logic [RANK_BITS-1:0]    rank;
        logic [SIZES_BITS-1:0]   axis_sizes;
        logic [STRIDES_BITS-1:0] source_strides;
        logic [STRIDES_BITS-1:0] dest_strides;
        logic                    dest_contiguous;
        logic [ESIZE_BITS-1:0]   element_size_log2;
    } t_cfg;

    typedef enum logic {
        ALU_ADD,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [BASE_BITS-1:0] a;
        logic [BASE_BITS-1:0] b;
    } t_alu_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_ADD_SRC,
        ST_ADD_DST,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic busy;
        logic active;
    } t_seq_stat;

endpackage

`default_nettype wire

### design/scaw_alu.sv
// Shared arithmetic unit of the address walker: a wrapping add of two
// base-wide operands or a contiguous-stride times axis-size product.
// Depends on scaw_pkg.
`default_nettype none

module scaw_alu
    import scaw_pkg::*;
(
    input  t_alu_req             i_req,
    output logic [BASE_BITS-1:0] o_result
);

    logic [CSTRIDE_BITS+AXIS_BITS-1:0] w_prod;

    assign w_prod = i_req.a[CSTRIDE_BITS-1:0] * i_req.b[AXIS_BITS-1:0];

    always_comb begin
        case (i_req.op)
            ALU_ADD: o_result = i_req.a + i_req.b;
            ALU_MUL: o_result = BASE_BITS'(w_prod[CSTRIDE_BITS-1:0]);
            default: o_result = '0;
        endcase
    end

endmodule

`default_nettype wire

### design/scaw_seq.sv
// Sequencer of the address walker: walk state, contiguous stride setup,
// axis stepping through the shared unit and the output word register.
// Depends on scaw_pkg and scaw_alu.
`default_nettype none

module scaw_seq
    import scaw_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    input  logic                   i_restart,
    output logic                   o_stall,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [OFFSET_BITS-1:0] o_source_offset,
    output logic [OFFSET_BITS-1:0] o_dest_offset,
    output logic                   o_final_element,
    output t_seq_stat              o_stat
);

    t_state                  r_state, n_state;
    logic                    r_active, n_active;
    logic                    r_out_valid, n_out_valid;
    logic [IDX_BITS-1:0]     r_k, n_k;
    logic [CSTRIDE_BITS-1:0] r_mult, n_mult;
    logic [AXIS_BITS-1:0]    r_cnt [MAX_RANK];
    logic [AXIS_BITS-1:0]    n_cnt [MAX_RANK];
    logic [BASE_BITS-1:0]    r_sbase [MAX_RANK];
    logic [BASE_BITS-1:0]    n_sbase [MAX_RANK];
    logic [BASE_BITS-1:0]    r_dbase [MAX_RANK];
    logic [BASE_BITS-1:0]    n_dbase [MAX_RANK];
    logic [CSTRIDE_BITS-1:0] r_cstride [MAX_RANK];
    logic [CSTRIDE_BITS-1:0] n_cstride [MAX_RANK];
    logic [OFFSET_BITS-1:0]  r_src_off, n_src_off;
    logic [OFFSET_BITS-1:0]  r_dst_off, n_dst_off;
    logic                    r_final, n_final;

    logic [AXIS_BITS-1:0]    w_size [MAX_RANK];
    logic [BASE_BITS-1:0]    w_sstride [MAX_RANK];
    logic [BASE_BITS-1:0]    w_dstride [MAX_RANK];
    logic [MAX_RANK-1:0]     w_use;
    logic [MAX_RANK-1:0]     w_can_adv;
    logic [MAX_RANK-1:0]     w_size_zero;
    logic [IDX_BITS-1:0]     w_sel;
    logic                    w_last;
    logic                    w_zero;
    logic                    w_acc;
    t_alu_req                w_req;
    logic [BASE_BITS-1:0]    w_alu_y;

    scaw_alu u_alu (
        .i_req    (w_req),
        .o_result (w_alu_y)
    );

    always_comb begin
        for (int k = 0; k < MAX_RANK; k++) begin
            w_size[k]    = i_cfg.axis_sizes[k*AXIS_BITS +: AXIS_BITS];
            w_sstride[k] = BASE_BITS'(i_cfg.source_strides[k*STRIDE_BITS +: STRIDE_BITS]);
            if (i_cfg.dest_contiguous) begin
                w_dstride[k] = BASE_BITS'(r_cstride[k]);
            end else begin
                w_dstride[k] = BASE_BITS'(i_cfg.dest_strides[k*STRIDE_BITS +: STRIDE_BITS]);
            end
            w_use[k]       = (k < int'(i_cfg.rank));
            w_can_adv[k]   = w_use[k] &&
                             (({1'b0, r_cnt[k]} + 1'b1) < {1'b0, w_size[k]});
            w_size_zero[k] = w_use[k] && (w_size[k] == '0);
        end
    end

    always_comb begin
        w_sel = '0;
        for (int k = MAX_RANK - 1; k >= 0; k--) begin
            if (w_can_adv[k]) begin
                w_sel = IDX_BITS'(k);
            end
        end
    end

    assign w_last  = ~|w_can_adv;
    assign w_zero  = |w_size_zero;
    assign o_stall = !((r_state == ST_IDLE) && (!r_out_valid || !i_stall));
    assign w_acc   = i_valid && !o_stall;

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_out_valid = r_out_valid;
        n_k         = r_k;
        n_mult      = r_mult;
        n_cnt       = r_cnt;
        n_sbase     = r_sbase;
        n_dbase     = r_dbase;
        n_cstride   = r_cstride;
        n_src_off   = r_src_off;
        n_dst_off   = r_dst_off;
        n_final     = r_final;
        w_req.op    = ALU_ADD;
        w_req.a     = '0;
        w_req.b     = '0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    if (i_restart) begin
                        for (int k = 0; k < MAX_RANK; k++) begin
                            n_cnt[k]   = '0;
                            n_sbase[k] = '0;
                            n_dbase[k] = '0;
                        end
                        n_mult  = CSTRIDE_BITS'(1);
                        n_k     = '0;
                        n_state = ST_MUL;
                    end else if (r_active) begin
                        if (!w_last) begin
                            n_k     = w_sel;
                            n_state = ST_ADD_SRC;
                        end else begin
                            n_active = 1'b0;
                        end
                    end
                end
            end
            ST_MUL: begin
                w_req.op = ALU_MUL;
                w_req.a  = BASE_BITS'(r_mult);
                w_req.b  = BASE_BITS'(w_size[r_k]);
                n_cstride[r_k] = (w_size[r_k] == AXIS_BITS'(1)) ? '0 : r_mult;
                n_mult = w_alu_y[CSTRIDE_BITS-1:0];
                if (r_k == IDX_BITS'(MAX_RANK - 1)) begin
                    n_state = ST_CHECK;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_CHECK: begin
                if (w_zero) begin
                    n_active = 1'b0;
                    n_state  = ST_IDLE;
                end else begin
                    n_active = 1'b1;
                    n_state  = ST_EMIT;
                end
            end
            ST_ADD_SRC: begin
                w_req.a      = r_sbase[r_k];
                w_req.b      = w_sstride[r_k];
                n_sbase[r_k] = w_alu_y;
                n_state      = ST_ADD_DST;
            end
            ST_ADD_DST: begin
                w_req.a      = r_dbase[r_k];
                w_req.b      = w_dstride[r_k];
                n_dbase[r_k] = w_alu_y;
                n_cnt[r_k]   = r_cnt[r_k] + 1'b1;
                for (int j = 0; j < MAX_RANK; j++) begin
                    if (IDX_BITS'(j) < r_k) begin
                        n_cnt[j]   = '0;
                        n_sbase[j] = r_sbase[r_k];
                        n_dbase[j] = w_alu_y;
                    end
                end
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_out_valid = 1'b1;
                n_src_off   = OFFSET_BITS'(r_sbase[0]) << i_cfg.element_size_log2;
                n_dst_off   = OFFSET_BITS'(r_dbase[0]) << i_cfg.element_size_log2;
                n_final     = w_last;
                if (w_last) begin
                    n_active = 1'b0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_mult    <= n_mult;
        r_cnt     <= n_cnt;
        r_sbase   <= n_sbase;
        r_dbase   <= n_dbase;
        r_cstride <= n_cstride;
        r_src_off <= n_src_off;
        r_dst_off <= n_dst_off;
        r_final   <= n_final;
    end

    assign o_valid         = r_out_valid;
    assign o_source_offset = r_src_off;
    assign o_dest_offset   = r_dst_off;
    assign o_final_element = r_final;
    assign o_stat.busy     = (r_state != ST_IDLE);
    assign o_stat.active   = r_active;

endmodule

`default_nettype wire

### design/strided_copy_address_walk.sv
// Address walker for an N-dimensional strided copy: one word in, at most one
// address pair out. An advance word passes the source add, destination add
// and emit states before its pair; the next word is taken only once idle again,
// as the single shared adder does the source and destination adds in turn.
// A restart word runs one multiply per axis on the same unit, then a check and
// an emit state. Reset is synchronous, active low, and clears the walk.
`default_nettype none

module strided_copy_address_walk
    import scaw_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_restart,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [OFFSET_BITS-1:0]    o_source_offset,
    output logic [OFFSET_BITS-1:0]    o_dest_offset,
    output logic                      o_final_element
);

    t_cfg      r_cfg;
    t_seq_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rank              <= '0;
            r_cfg.axis_sizes        <= '0;
            r_cfg.source_strides    <= '0;
            r_cfg.dest_strides      <= '0;
            r_cfg.dest_contiguous   <= 1'b1;
            r_cfg.element_size_log2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RANK:           r_cfg.rank <= i_cfg_data[RANK_BITS-1:0];
                CFG_AXIS_SIZES:     r_cfg.axis_sizes <= i_cfg_data[SIZES_BITS-1:0];
                CFG_SOURCE_STRIDES: r_cfg.source_strides <= i_cfg_data[STRIDES_BITS-1:0];
                CFG_DEST_STRIDES:   r_cfg.dest_strides <= i_cfg_data[STRIDES_BITS-1:0];
                CFG_DEST_CONTIG:    r_cfg.dest_contiguous <= i_cfg_data[0];
                CFG_ESIZE_LOG2:     r_cfg.element_size_log2 <= i_cfg_data[ESIZE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    scaw_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .i_restart       (i_restart),
        .o_stall         (o_stall),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_source_offset (o_source_offset),
        .o_dest_offset   (o_dest_offset),
        .o_final_element (o_final_element),
        .o_stat          (w_stat)
    );

    a_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_restart) |=> (o_stall && w_stat.busy))
        else $error("restart word did not start the stride setup");

    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_stat.busy))
        else $error("output word appeared without sequencer work");

    a_final_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_final_element) |-> !w_stat.active)
        else $error("walk still active while its final word is pending");

endmodule

`default_nettype wire
